FILE: src/tcf_pkg.sv
// Package for the tilt complementary filter: widths, constants, codes and types.
// The arctangent table and the 24-bit saturation live here. No dependencies.
package tcf_pkg;

   localparam int IN_W     = 16;
   localparam int OBS_W    = 19;
   localparam int ST_W     = 24;
   localparam int MA_W     = 33;
   localparam int MB_W     = 17;
   localparam int MP_W     = 51;
   localparam int DIFF_W   = 26;
   localparam int CX_W     = 32;
   localparam int CZ_W     = 20;
   localparam int TAB_IW   = 5;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 17;
   localparam int REQ_W    = 48;
   localparam int RSP_W    = 72;

   // 0.0174533 * 2^48 / (1000 * 256), split for the 17-bit multiplier port
   localparam logic [15:0] RATE_SCALE_LO = 16'd53594;
   localparam logic [8:0]  RATE_SCALE_HI = 9'd292;

   localparam logic signed [CZ_W-1:0] PI_Q16    = 20'sd205887;
   localparam logic signed [CZ_W-1:0] OBS_LIMIT = 20'sd205888;
   localparam logic [MB_W-1:0]        BLEND_ONE = 17'd65536;

   localparam logic [15:0]        GYRO_SENS_RST  = 16'd2240;
   localparam logic [15:0]        TIME_STEP_RST  = 16'd655;
   localparam logic [15:0]        BIAS_GAIN_RST  = 16'd66;
   localparam logic [MB_W-1:0]    BLEND_GAIN_RST = 17'd64225;

   typedef enum logic [CSR_AW-1:0] {
      CSR_GYRO_SENS  = 3'd0,
      CSR_TIME_STEP  = 3'd1,
      CSR_BIAS_GAIN  = 3'd2,
      CSR_BLEND_GAIN = 3'd3,
      CSR_AX_OFFSET  = 3'd4
   } tcf_csr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GS,
      ST_RLO,
      ST_RHI,
      ST_RDIF,
      ST_EST,
      ST_ESTW,
      ST_WOBS,
      ST_BIAS,
      ST_BLEND,
      ST_ANG,
      ST_OUT
   } tcf_state_type;

   typedef struct packed {
      logic                    done;
      logic signed [OBS_W-1:0] angle;
   } tcf_obs_type;

   function automatic logic [15:0] atan_q16(input logic [TAB_IW-1:0] idx);
      logic [15:0] v;
      case (idx)
         5'd0:    v = 16'd51472;
         5'd1:    v = 16'd30386;
         5'd2:    v = 16'd16055;
         5'd3:    v = 16'd8150;
         5'd4:    v = 16'd4091;
         5'd5:    v = 16'd2047;
         5'd6:    v = 16'd1024;
         5'd7:    v = 16'd512;
         5'd8:    v = 16'd256;
         5'd9:    v = 16'd128;
         5'd10:   v = 16'd64;
         5'd11:   v = 16'd32;
         5'd12:   v = 16'd16;
         5'd13:   v = 16'd8;
         5'd14:   v = 16'd4;
         5'd15:   v = 16'd2;
         5'd16:   v = 16'd1;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [ST_W-1:0] sat24(input logic signed [34:0] v);
      logic signed [ST_W-1:0] r;
      if (v > 35'sd8388607) begin
         r = 24'sh7FFFFF;
      end else if (v < -35'sd8388608) begin
         r = 24'sh800000;
      end else begin
         r = v[ST_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: src/tcf_mac.sv
// Shared multiply-add unit: p = a * b + c, registered, one result per enable.
// Uses tcf_pkg for operand widths.
module tcf_mac import tcf_pkg::*; (
   input  logic                   clock,
   input  logic                   en,
   input  logic signed [MA_W-1:0] a,
   input  logic        [MB_W-1:0] b,
   input  logic signed [MP_W-1:0] c,
   output logic signed [MP_W-1:0] p
);

   logic signed [MP_W-1:0] p_ff;
   logic signed [MP_W-1:0] p_in;
   logic signed [MB_W:0]   b_s;

   assign b_s  = signed'({1'b0, b});
   assign p_in = a * b_s + c;

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
      end
   end

   assign p = p_ff;

endmodule

FILE: src/tcf_cordic.sv
// Iterative vectoring CORDIC: atan2(y, x) in Q.16 radians, one step per cycle.
// Uses tcf_pkg for the arctangent table, pi and the result struct.
module tcf_cordic import tcf_pkg::*; #(
   parameter int STEPS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic signed [IN_W-1:0] x_in,
   input  logic signed [17:0]     y_in,
   output tcf_obs_type            obs
);

   localparam int SW = $clog2(STEPS);

   logic                   run_ff, run_in;
   logic                   done_ff, done_in;
   logic [SW-1:0]          step_ff, step_in;
   logic signed [CX_W-1:0] x_ff, x_in_r;
   logic signed [CX_W-1:0] y_ff, y_in_r;
   logic signed [CZ_W-1:0] z_ff, z_in;

   logic                   zero_vec;
   logic signed [16:0]     x_pre;
   logic signed [18:0]     y_pre;
   logic signed [CZ_W-1:0] z_pre;
   logic signed [CX_W-1:0] xs, ys;
   logic signed [CZ_W-1:0] at;
   logic                   last;

   assign zero_vec = (x_in == '0) && (y_in == '0);
   assign x_pre    = x_in[IN_W-1] ? -17'(x_in) : 17'(x_in);
   assign y_pre    = x_in[IN_W-1] ? -19'(y_in) : 19'(y_in);
   assign z_pre    = !x_in[IN_W-1] ? '0 : (!y_in[17] ? PI_Q16 : -PI_Q16);

   assign xs   = x_ff >>> step_ff;
   assign ys   = y_ff >>> step_ff;
   assign at   = signed'(CZ_W'(atan_q16(TAB_IW'(step_ff))));
   assign last = (step_ff == SW'(STEPS - 1));

   always_comb begin
      run_in  = run_ff;
      done_in = done_ff;
      step_in = step_ff;
      x_in_r  = x_ff;
      y_in_r  = y_ff;
      z_in    = z_ff;
      if (start) begin
         run_in  = !zero_vec;
         done_in = zero_vec;
         step_in = '0;
         x_in_r  = CX_W'(x_pre) <<< 12;
         y_in_r  = CX_W'(y_pre) <<< 12;
         z_in    = zero_vec ? '0 : z_pre;
      end else if (run_ff) begin
         if (y_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            if (!y_ff[CX_W-1]) begin
               x_in_r = x_ff + ys;
               y_in_r = y_ff - xs;
               z_in   = z_ff + at;
            end else begin
               x_in_r = x_ff - ys;
               y_in_r = y_ff + xs;
               z_in   = z_ff - at;
            end
            if (last) begin
               run_in  = 1'b0;
               done_in = 1'b1;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in_r;
      y_ff <= y_in_r;
      z_ff <= z_in;
   end

   always_comb begin
      obs.done = done_ff;
      if (z_ff > OBS_LIMIT) begin
         obs.angle = OBS_W'(OBS_LIMIT);
      end else if (z_ff < -OBS_LIMIT) begin
         obs.angle = OBS_W'(-OBS_LIMIT);
      end else begin
         obs.angle = z_ff[OBS_W-1:0];
      end
   end

endmodule

FILE: src/tilt_complementary_filter_top.sv
// Tilt complementary filter top: sequencer around one shared multiply-add unit.
// After an item is taken the states GS, RLO, RHI, RDIF, EST, ESTW, WOBS, BIAS, BLEND, ANG, OUT
// follow; req_tready is high only in IDLE and the CORDIC, awaited in WOBS, sets the pace.
// Reset (synchronous, active high): registers to defaults, angle and bias estimates to zero.
// Depends on tcf_pkg, tcf_mac and tcf_cordic.
module tilt_complementary_filter_top import tcf_pkg::*; #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_W-1:0]  req_tdata,   // gyro_rate, accel_x, accel_z
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata,   // observed_angle, estimated_angle, gyro_bias, zero pad
   input  logic              csr_wen,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [CSR_DW-1:0] csr_wdata
);

   tcf_state_type state_ff, state_in;

   logic [15:0]             gyro_sens_ff, time_step_ff, bias_gain_ff;
   logic [MB_W-1:0]         blend_gain_ff;
   logic signed [IN_W-1:0]  ax_off_ff;

   logic signed [IN_W-1:0]  gyro_ff, ax_ff, az_ff;
   logic signed [31:0]      p_ff;
   logic signed [DIFF_W-1:0] diff_ff;
   logic signed [ST_W-1:0]  est_ff, angle_ff, bias_ff;
   logic                    rsp_valid_ff;
   logic [RSP_W-1:0]        rsp_data_ff;

   logic                    accept, cordic_start, mac_en;
   logic                    ld_p, ld_rdif, ld_est, ld_odif, ld_bias, ld_angle, ld_out;
   logic signed [MA_W-1:0]  mac_a;
   logic [MB_W-1:0]         mac_b;
   logic signed [MP_W-1:0]  mac_c, mac_p;
   logic signed [ST_W-1:0]  mac_sat;
   logic [MB_W-1:0]         k;
   logic signed [17:0]      cordic_y;
   tcf_obs_type             obs;

   assign accept     = req_tvalid && req_tready;
   assign k          = (blend_gain_ff > BLEND_ONE) ? BLEND_ONE : blend_gain_ff;
   assign mac_sat    = sat24(mac_p[MP_W-1:16]);
   assign cordic_y   = -(18'(ax_ff) - 18'(ax_off_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_GS;
         ST_GS:    state_in = ST_RLO;
         ST_RLO:   state_in = ST_RHI;
         ST_RHI:   state_in = ST_RDIF;
         ST_RDIF:  state_in = ST_EST;
         ST_EST:   state_in = ST_ESTW;
         ST_ESTW:  state_in = ST_WOBS;
         ST_WOBS:  if (obs.done) state_in = ST_BIAS;
         ST_BIAS:  state_in = ST_BLEND;
         ST_BLEND: state_in = ST_ANG;
         ST_ANG:   state_in = ST_OUT;
         ST_OUT:   if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready   = 1'b0;
      cordic_start = 1'b0;
      mac_en       = 1'b0;
      mac_a        = '0;
      mac_b        = '0;
      mac_c        = '0;
      ld_p         = 1'b0;
      ld_rdif      = 1'b0;
      ld_est       = 1'b0;
      ld_odif      = 1'b0;
      ld_bias      = 1'b0;
      ld_angle     = 1'b0;
      ld_out       = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_GS: begin
            cordic_start = 1'b1;
            mac_en       = 1'b1;
            mac_a        = MA_W'(gyro_ff);
            mac_b        = MB_W'(gyro_sens_ff);
         end
         ST_RLO: begin
            ld_p   = 1'b1;
            mac_en = 1'b1;
            mac_a  = MA_W'(signed'(mac_p[31:0]));
            mac_b  = MB_W'(RATE_SCALE_LO);
            mac_c  = MP_W'(signed'({1'b0, 32'h8000_0000}));
         end
         ST_RHI: begin
            mac_en = 1'b1;
            mac_a  = MA_W'(p_ff);
            mac_b  = MB_W'(RATE_SCALE_HI);
            mac_c  = MP_W'(signed'(mac_p[MP_W-1:16]));
         end
         ST_RDIF: ld_rdif = 1'b1;
         ST_EST: begin
            mac_en = 1'b1;
            mac_a  = MA_W'(diff_ff);
            mac_b  = MB_W'(time_step_ff);
            mac_c  = MP_W'(signed'({angle_ff, 16'h8000}));
         end
         ST_ESTW: ld_est = 1'b1;
         ST_WOBS: ld_odif = obs.done;
         ST_BIAS: begin
            mac_en = 1'b1;
            mac_a  = MA_W'(diff_ff);
            mac_b  = MB_W'(bias_gain_ff);
            mac_c  = MP_W'(signed'({bias_ff, 16'h8000}));
         end
         ST_BLEND: begin
            ld_bias = 1'b1;
            mac_en  = 1'b1;
            mac_a   = MA_W'(diff_ff);
            mac_b   = k;
            mac_c   = MP_W'(signed'({obs.angle, 16'h8000}));
         end
         ST_ANG: ld_angle = 1'b1;
         ST_OUT: ld_out = !rsp_valid_ff || rsp_tready;
         default: req_tready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         gyro_sens_ff  <= GYRO_SENS_RST;
         time_step_ff  <= TIME_STEP_RST;
         bias_gain_ff  <= BIAS_GAIN_RST;
         blend_gain_ff <= BLEND_GAIN_RST;
         ax_off_ff     <= '0;
         angle_ff      <= '0;
         bias_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wen) begin
            unique case (csr_addr)
               CSR_GYRO_SENS:  gyro_sens_ff  <= csr_wdata[15:0];
               CSR_TIME_STEP:  time_step_ff  <= csr_wdata[15:0];
               CSR_BIAS_GAIN:  bias_gain_ff  <= csr_wdata[15:0];
               CSR_BLEND_GAIN: blend_gain_ff <= csr_wdata;
               CSR_AX_OFFSET:  ax_off_ff     <= signed'(csr_wdata[15:0]);
               default:        ;
            endcase
         end
         if (ld_bias) begin
            bias_ff <= mac_sat;
         end
         if (ld_angle) begin
            angle_ff <= mac_sat;
         end
         if (ld_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         gyro_ff <= signed'(req_tdata[15:0]);
         ax_ff   <= signed'(req_tdata[31:16]);
         az_ff   <= signed'(req_tdata[47:32]);
      end
      if (ld_p) begin
         p_ff <= mac_p[31:0];
      end
      if (ld_rdif) begin
         diff_ff <= signed'(mac_p[DIFF_W+15:16]) - DIFF_W'(bias_ff);
      end
      if (ld_est) begin
         est_ff <= mac_sat;
      end
      if (ld_odif) begin
         diff_ff <= DIFF_W'(est_ff) - DIFF_W'(obs.angle);
      end
      if (ld_out) begin
         rsp_data_ff <= {5'b0, bias_ff, angle_ff, obs.angle};
      end
   end

   tcf_mac u_mac (
      .clock (clock),
      .en    (mac_en),
      .a     (mac_a),
      .b     (mac_b),
      .c     (mac_c),
      .p     (mac_p)
   );

   tcf_cordic #(
      .STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .x_in  (az_ff),
      .y_in  (cordic_y),
      .obs   (obs)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("input taken again while an item is in work");

   a_obs_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (signed'(rsp_data_ff[OBS_W-1:0]) <= 19'sd205888 &&
                        signed'(rsp_data_ff[OBS_W-1:0]) >= -19'sd205888))
      else $error("observed angle outside of +/- pi clamp");

   a_wait_obs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WOBS && !obs.done) |=> state_ff == ST_WOBS)
      else $error("blend started before CORDIC finished");
`endif

endmodule

FILE: sim/tilt_filter_checker.sv
// Watches the sample, result and register ports of the tilt complementary filter, predicts
// each result from its own copy of the gains and filter state, and counts mismatches.
// Depends on tcf_pkg for widths and register codes.
module tilt_filter_checker import tcf_pkg::*; #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [REQ_W-1:0]  req_tdata,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [RSP_W-1:0]  rsp_tdata,
   input  logic              csr_wen,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [CSR_DW-1:0] csr_wdata,
   output int                mismatches,
   output int                outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // round(0.0174533 * 2^48 / (1000 * 256))
   localparam longint RATE_FACTOR = 19190106;
   localparam longint PI_RAD      = 205887;
   localparam longint OBS_CLAMP   = 205888;
   localparam longint ST_MAX      = 8388607;
   localparam longint ST_MIN      = -8388608;
   localparam longint UNITY       = 65536;

   typedef struct {
      logic signed [OBS_W-1:0] observed;
      logic signed [ST_W-1:0]  estimated;
      logic signed [ST_W-1:0]  bias;
   } tilt_result_type;

   int atan_step [24] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                          256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};

   int     gyro_sens, time_step, bias_gain, blend_gain, ax_offset;
   longint angle_est, bias_est;

   tilt_result_type pending_tilts [$];

   function automatic longint round_q16(input longint v);
      return (v + 32768) >>> 16;
   endfunction

   function automatic longint clamp24(input longint v);
      if (v > ST_MAX) return ST_MAX;
      if (v < ST_MIN) return ST_MIN;
      return v;
   endfunction

   function automatic longint tilt_atan2(input longint yin, input longint xin);
      longint xv, yv, zv, nx, ny;
      int     i;
      xv = xin;
      yv = yin;
      zv = 0;
      if (xv == 0 && yv == 0) return 0;
      if (xv < 0) begin
         zv = (yv >= 0) ? PI_RAD : -PI_RAD;
         xv = -xv;
         yv = -yv;
      end
      xv = xv * 4096;
      yv = yv * 4096;
      for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
         if (yv == 0) break;
         if (yv > 0) begin
            nx = xv + (yv >>> i);
            ny = yv - (xv >>> i);
            zv = zv + atan_step[i];
         end else begin
            nx = xv - (yv >>> i);
            ny = yv + (xv >>> i);
            zv = zv - atan_step[i];
         end
         xv = nx;
         yv = ny;
      end
      if (zv > OBS_CLAMP) zv = OBS_CLAMP;
      if (zv < -OBS_CLAMP) zv = -OBS_CLAMP;
      return zv;
   endfunction

   // advances the filter state by one sample
   function automatic tilt_result_type fuse_sample(input logic [REQ_W-1:0] item);
      tilt_result_type r;
      longint          g, ax, az, rate, obs, est, k;
      g    = longint'($signed(item[15:0]));
      ax   = longint'($signed(item[31:16]));
      az   = longint'($signed(item[47:32]));
      rate = (g * gyro_sens * RATE_FACTOR + (longint'(1) <<< 31)) >>> 32;
      obs  = tilt_atan2(-(ax - ax_offset), az);
      est  = clamp24(angle_est + round_q16((rate - bias_est) * time_step));
      bias_est  = clamp24(bias_est + round_q16((est - obs) * bias_gain));
      k         = (blend_gain > UNITY) ? UNITY : longint'(blend_gain);
      angle_est = clamp24(round_q16(k * est + (UNITY - k) * obs));
      r.observed  = OBS_W'(obs);
      r.estimated = ST_W'(angle_est);
      r.bias      = ST_W'(bias_est);
      return r;
   endfunction

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch
      tilt_result_type want;
      if (reset) begin
         gyro_sens   = int'(GYRO_SENS_RST);
         time_step   = int'(TIME_STEP_RST);
         bias_gain   = int'(BIAS_GAIN_RST);
         blend_gain  = int'(BLEND_GAIN_RST);
         ax_offset   = 0;
         angle_est   = 0;
         bias_est    = 0;
         mismatches  = 0;
         pending_tilts.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_tilts.size() == 0) begin
               $error("result item with none expected: observed_angle %0d",
                      $signed(rsp_tdata[OBS_W-1:0]));
               mismatches++;
            end else begin
               want = pending_tilts.pop_front();
               check_field("observed_angle", longint'(want.observed),
                           longint'($signed(rsp_tdata[OBS_W-1:0])));
               check_field("estimated_angle", longint'(want.estimated),
                           longint'($signed(rsp_tdata[OBS_W+ST_W-1:OBS_W])));
               check_field("gyro_bias", longint'(want.bias),
                           longint'($signed(rsp_tdata[OBS_W+2*ST_W-1:OBS_W+ST_W])));
            end
         end
         if (req_tvalid && req_tready) pending_tilts.push_back(fuse_sample(req_tdata));
         if (csr_wen) begin
            case (csr_addr)
               CSR_GYRO_SENS:  gyro_sens  = int'(csr_wdata[15:0]);
               CSR_TIME_STEP:  time_step  = int'(csr_wdata[15:0]);
               CSR_BIAS_GAIN:  bias_gain  = int'(csr_wdata[15:0]);
               CSR_BLEND_GAIN: blend_gain = int'(csr_wdata);
               CSR_AX_OFFSET:  ax_offset  = int'($signed(csr_wdata[15:0]));
               default: ;
            endcase
         end
      end
      outstanding = pending_tilts.size();
   end

endmodule

FILE: sim/testbench.sv
// Top of the tilt complementary filter simulation: clock, reset, sample stimulus, gain
// programming and the verdict. Depends on tcf_pkg, the filter RTL and tilt_filter_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import tcf_pkg::*;

   localparam int STEPS = 16;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata;   // gyro_rate, accel_x, accel_z
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_W-1:0]  rsp_tdata;   // observed_angle, estimated_angle, gyro_bias, zero pad
   logic              csr_wen;
   logic [CSR_AW-1:0] csr_addr;
   logic [CSR_DW-1:0] csr_wdata;
   int                mismatches;
   int                outstanding;
   logic              quiet;
   int                ax_offset_now;

   tilt_complementary_filter_top #(.CORDIC_STEPS(STEPS)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   tilt_filter_checker #(.CORDIC_STEPS(STEPS)) i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wen     (csr_wen),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("testbench: FAIL");
      $finish;
   end

   // result side: random stall before each item
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 7);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   task automatic send_sample(input logic signed [15:0] gyro, input logic signed [15:0] ax,
                              input logic signed [15:0] az);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {az, ax, gyro};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // stop sending and wait for every result
   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic csr_write(input tcf_csr_type idx, input logic [CSR_DW-1:0] value);
      csr_wen   <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic signed [15:0] near_offset(input int span);
      int v;
      v = ax_offset_now + $urandom_range(0, 2 * span) - span;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return 16'(v);
   endfunction

   task automatic random_sample();
      int                 mode;
      logic signed [15:0] gyro, ax, az;
      mode = $urandom_range(0, 9);
      gyro = 16'($urandom);
      ax   = 16'($urandom);
      az   = 16'($urandom);
      case (mode)
         5, 6: begin
            // near level, realistic gravity on z
            gyro = 16'($urandom_range(0, 255) - 128);
            ax   = near_offset(2048);
            az   = 16'(14336 + $urandom_range(0, 4095));
         end
         7: begin
            // upside down, tiny x: pi wrap and clamp
            ax = near_offset(3);
            az = 16'(-32768 + $urandom_range(0, 511));
         end
         8: begin
            if ($urandom_range(0, 1) == 1) az = 0;
            else ax = 16'(ax_offset_now);
         end
         9: begin
            ax = near_offset(3);
            az = 16'($urandom_range(0, 6) - 3);
         end
         default: ;
      endcase
      send_sample(gyro, ax, az);
   endtask

   task automatic load_gains(input int phase);
      logic [15:0]       sens, step, bgain;
      logic [CSR_DW-1:0] blend;
      int                offs;
      sens  = GYRO_SENS_RST;
      step  = TIME_STEP_RST;
      bgain = BIAS_GAIN_RST;
      blend = BLEND_GAIN_RST;
      offs  = 0;
      case (phase)
         1: begin
            sens = 16'hFFFF; step = 16'hFFFF; bgain = 16'hFFFF; blend = '1; offs = 32767;
         end
         2: begin
            sens = '0; step = '0; bgain = '0; blend = '0; offs = -32768;
         end
         3: blend = BLEND_ONE;
         4: begin
            blend = CSR_DW'($urandom_range(65537, 131071));
            offs  = $urandom_range(0, 4095) - 2048;
         end
         5, 6: begin
            sens  = 16'($urandom_range(1000, 4000));
            step  = 16'($urandom_range(100, 2000));
            bgain = 16'($urandom_range(0, 1000));
            blend = CSR_DW'($urandom_range(60000, 65536));
            offs  = $urandom_range(0, 4095) - 2048;
         end
         7, 8, 9: begin
            sens  = 16'($urandom);
            step  = 16'($urandom);
            bgain = 16'($urandom);
            blend = CSR_DW'($urandom_range(0, 131071));
            offs  = $urandom_range(0, 65535) - 32768;
         end
         default: ;
      endcase
      csr_write(CSR_GYRO_SENS, CSR_DW'(sens));
      csr_write(CSR_TIME_STEP, CSR_DW'(step));
      csr_write(CSR_BIAS_GAIN, CSR_DW'(bgain));
      csr_write(CSR_BLEND_GAIN, blend);
      csr_write(CSR_AX_OFFSET, CSR_DW'(offs));
      ax_offset_now = offs;
   endtask

   initial begin
      int i, phase;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      csr_wen       = 1'b0;
      csr_addr      = CSR_GYRO_SENS;
      csr_wdata     = '0;
      quiet         = 1'b0;
      ax_offset_now = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed samples at reset gains
      send_sample(0, 0, 0);
      send_sample(32767, -32768, 32767);
      send_sample(-32768, 32767, -32768);
      send_sample(0, 0, -100);
      send_sample(0, 0, -32768);
      send_sample(100, 32767, 0);
      send_sample(-100, -32768, 0);
      send_sample(0, 0, 16384);
      send_sample(0, -1, 1);
      send_sample(0, -5, -32768);
      send_sample(0, -1, -32767);
      send_sample(0, 1, -32768);
      send_sample(0, 3, -32000);
      send_sample(32767, 0, 0);
      send_sample(-32768, 0, 0);
      send_sample(1, -1, -1);
      send_sample(-1, 1, 1);
      send_sample(16'sh5555, 16'shAAAA, 16'sh5555);
      send_sample(16'shAAAA, 16'sh5555, 16'shAAAA);
      send_sample(0, 32767, 32767);
      send_sample(0, -32768, -32768);

      for (i = 0; i < 100; i++) begin
         if (i % 40 == 0) quiet = ($urandom_range(0, 2) == 0);
         random_sample();
      end
      for (phase = 1; phase <= 10; phase++) begin
         drain();
         load_gains(phase);
         for (i = 0; i < 113; i++) begin
            if (i % 40 == 0) quiet = ($urandom_range(0, 2) == 0);
            random_sample();
         end
      end
      drain();
      repeat (30) @(negedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/tcf_pkg.sv
src/tcf_mac.sv
src/tcf_cordic.sv
src/tilt_complementary_filter_top.sv
sim/tilt_filter_checker.sv
sim/testbench.sv
